@@ src/fss_pkg.sv @@
// Package for the file name segment sanitizer: sizes, character codes,
// result item types and the byte classification and name decision functions.
// No dependencies.
package fss_pkg;

  localparam int HOLDBACK_DEPTH = 5;
  localparam int MAX_RES        = HOLDBACK_DEPTH + 1;
  localparam int HB_IW          = $clog2(HOLDBACK_DEPTH);
  localparam int HB_LW          = $clog2(HOLDBACK_DEPTH + 1);
  localparam int RES_CW         = $clog2(MAX_RES + 1);
  localparam int Q_DEPTH        = MAX_RES + 2;
  localparam int Q_CW           = $clog2(Q_DEPTH + 1);

  localparam logic [15:0] CAP_RESET = 16'd64;

  localparam logic [7:0] CH_US   = 8'h5F;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7A;

  localparam logic [23:0] W_CON = "con";
  localparam logic [23:0] W_PRN = "prn";
  localparam logic [23:0] W_AUX = "aux";
  localparam logic [23:0] W_NUL = "nul";
  localparam logic [23:0] W_COM = "com";
  localparam logic [23:0] W_LPT = "lpt";
  localparam logic [31:0] FB_WORD = "item";

  localparam logic [1:0] ST_CLEAN    = 2'd0;
  localparam logic [1:0] ST_DIRTY    = 2'd1;
  localparam logic [1:0] ST_FALLBACK = 2'd2;
  localparam logic [1:0] ST_RESERVED = 2'd3;

  typedef logic [HOLDBACK_DEPTH-1:0][7:0] hold_t;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       final_byte;
    logic [1:0] status;
  } res_t;

  // results caused by one item, in order, count of them valid
  typedef struct packed {
    logic [RES_CW-1:0]       count;
    res_t [MAX_RES-1:0]      items;
  } burst_t;

  typedef struct packed {
    logic [RES_CW-1:0]       n;
    logic [MAX_RES-1:0][7:0] b;
  } build_t;

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  function automatic logic allowed(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_0 && c <= CH_9) || c == CH_DOT || c == CH_DASH || c == CH_US;
  endfunction

  // base is the held bytes up to the first dot, or all len of them
  function automatic logic is_reserved(hold_t hb, logic [HB_LW-1:0] len);
    logic [HB_LW-1:0] b;
    logic [23:0]      w;
    logic             dig;
    b = len;
    for (int i = HOLDBACK_DEPTH - 1; i >= 0; i--) begin
      if (HB_LW'(i) < len && hb[i] == CH_DOT) begin
        b = HB_LW'(i);
      end
    end
    w   = {fold(hb[0]), fold(hb[1]), fold(hb[2])};
    dig = hb[3] >= CH_1 && hb[3] <= CH_9;
    return (b == HB_LW'(3) && (w == W_CON || w == W_PRN || w == W_AUX || w == W_NUL)) ||
           (b == HB_LW'(4) && dig && (w == W_COM || w == W_LPT));
  endfunction

  // held bytes, optionally behind an underscore, cut to the output limit
  function automatic build_t build_name(hold_t hb, logic rsv, logic [HB_LW-1:0] len,
                                        logic [15:0] limit);
    build_t           r;
    logic [15:0]      lim2;
    logic [HB_LW-1:0] take;
    lim2 = rsv ? limit - 16'd1 : limit;
    take = (lim2 < 16'(len)) ? lim2[HB_LW-1:0] : len;
    r.b  = rsv ? {hb, CH_US} : {8'h00, hb};
    r.n  = RES_CW'(take) + RES_CW'(rsv);
    return r;
  endfunction

endpackage

@@ src/fss_core.sv @@
// Name state and per-item decision logic: hold-back buffer, counters,
// reserved/fallback decision and the result burst for one item.
// Depends on fss_pkg.
module fss_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            char_byte,
  input  logic                  has_char,
  input  logic                  end_of_name,
  input  logic [15:0]           name_capacity,
  output fss_pkg::burst_t       burst
);

  typedef enum logic [1:0] {
    PH_HOLD  = 2'd0,
    PH_PLAIN = 2'd1,
    PH_RSV   = 2'd2
  } phase_t;

  fss_pkg::hold_t hb_r, hb_a, hb_nxt;
  logic [15:0]    kept_r, kept_a, kept_nxt;
  logic [15:0]    emit_r, emit_a, emit_nxt;
  logic           clean_r, clean_a, clean_nxt;
  phase_t         phase_r, phase_nxt, phase_aft;

  logic [15:0]    limit;
  logic [7:0]     c;
  logic           ok;
  logic           trig;
  logic           strm_emit;
  logic [7:0]     strm_byte;
  logic [fss_pkg::HB_LW-1:0]  blen;
  logic           rsv;
  logic           dot;
  fss_pkg::build_t bld;
  logic [fss_pkg::RES_CW-1:0] nf;
  logic [fss_pkg::RES_CW-1:0] pos;
  logic [1:0]     st;

  assign limit = ((name_capacity < 16'd2) ? 16'd2 : name_capacity) - 16'd1;
  assign ok    = fss_pkg::allowed(char_byte);
  assign c     = ok ? char_byte : fss_pkg::CH_US;

  // byte part of the step
  always_comb begin
    hb_a      = hb_r;
    kept_a    = kept_r;
    emit_a    = emit_r;
    clean_a   = clean_r;
    trig      = 1'b0;
    strm_emit = 1'b0;
    strm_byte = hb_r[0];
    if (has_char) begin
      if (!ok) begin
        clean_a = 1'b0;
      end
      if (kept_r >= limit) begin
        clean_a = 1'b0;
      end else if (phase_r == PH_HOLD) begin
        hb_a[kept_r[fss_pkg::HB_IW-1:0]] = c;
        kept_a = kept_r + 16'd1;
        trig   = kept_r == 16'(fss_pkg::HOLDBACK_DEPTH - 1);
      end else begin
        kept_a = kept_r + 16'd1;
        if (emit_r < limit) begin
          strm_emit = 1'b1;
          hb_a[0]   = c;
          emit_a    = emit_r + 16'd1;
        end
      end
    end
  end

  assign blen = (kept_a >= 16'(fss_pkg::HOLDBACK_DEPTH)) ?
                fss_pkg::HB_LW'(fss_pkg::HOLDBACK_DEPTH) : kept_a[fss_pkg::HB_LW-1:0];
  assign rsv  = fss_pkg::is_reserved(hb_a, blen);
  assign bld  = fss_pkg::build_name(hb_a, rsv, blen, limit);
  assign dot  = kept_a == 16'd0 ||
                (kept_a == 16'd1 && hb_a[0] == fss_pkg::CH_DOT) ||
                (kept_a == 16'd2 && hb_a[0] == fss_pkg::CH_DOT &&
                 hb_a[1] == fss_pkg::CH_DOT);
  assign nf   = (limit < 16'd4) ? limit[fss_pkg::RES_CW-1:0] : fss_pkg::RES_CW'(4);

  // decision, end of name, result list
  always_comb begin
    hb_nxt    = hb_a;
    kept_nxt  = kept_a;
    emit_nxt  = emit_a;
    clean_nxt = clean_a;
    phase_nxt = phase_r;
    burst     = '0;
    st        = fss_pkg::ST_CLEAN;
    pos       = '0;
    if (trig) begin
      // all but the last built byte go out; the last one stays pending
      for (int i = 0; i < fss_pkg::MAX_RES; i++) begin
        if (fss_pkg::RES_CW'(i + 1) < bld.n) begin
          burst.items[i].name_byte = bld.b[i];
        end
        if (fss_pkg::RES_CW'(i + 1) == bld.n) begin
          hb_nxt[0] = bld.b[i];
        end
      end
      burst.count = bld.n - fss_pkg::RES_CW'(1);
      emit_nxt    = 16'(bld.n);
      phase_nxt   = rsv ? PH_RSV : PH_PLAIN;
    end else if (strm_emit) begin
      burst.items[0].name_byte = strm_byte;
      burst.count              = fss_pkg::RES_CW'(1);
    end
    phase_aft = phase_nxt;
    if (end_of_name) begin
      if (phase_aft == PH_HOLD) begin
        if (dot) begin
          for (int i = 0; i < 4; i++) begin
            burst.items[i].name_byte  = fss_pkg::FB_WORD[31 - 8 * i -: 8];
            burst.items[i].final_byte = fss_pkg::RES_CW'(i + 1) == nf;
            burst.items[i].status     = (fss_pkg::RES_CW'(i + 1) == nf) ?
                                        fss_pkg::ST_FALLBACK : fss_pkg::ST_CLEAN;
          end
          burst.count = nf;
        end else begin
          st = rsv ? fss_pkg::ST_RESERVED :
               (clean_a ? fss_pkg::ST_CLEAN : fss_pkg::ST_DIRTY);
          for (int i = 0; i < fss_pkg::MAX_RES; i++) begin
            burst.items[i].name_byte  = bld.b[i];
            burst.items[i].final_byte = fss_pkg::RES_CW'(i + 1) == bld.n;
            burst.items[i].status     = (fss_pkg::RES_CW'(i + 1) == bld.n) ?
                                        st : fss_pkg::ST_CLEAN;
          end
          burst.count = bld.n;
        end
      end else begin
        st  = (phase_aft == PH_RSV) ? fss_pkg::ST_RESERVED :
              (clean_a ? fss_pkg::ST_CLEAN : fss_pkg::ST_DIRTY);
        pos = burst.count;
        for (int i = 0; i < fss_pkg::MAX_RES; i++) begin
          if (fss_pkg::RES_CW'(i) == pos) begin
            burst.items[i].name_byte  = hb_nxt[0];
            burst.items[i].final_byte = 1'b1;
            burst.items[i].status     = st;
          end
        end
        burst.count = pos + fss_pkg::RES_CW'(1);
      end
      kept_nxt  = '0;
      emit_nxt  = '0;
      clean_nxt = 1'b1;
      phase_nxt = PH_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r  <= '0;
      emit_r  <= '0;
      clean_r <= 1'b1;
      phase_r <= PH_HOLD;
    end else if (step) begin
      kept_r  <= kept_nxt;
      emit_r  <= emit_nxt;
      clean_r <= clean_nxt;
      phase_r <= phase_nxt;
    end
  end

  // held bytes carry no reset; each entry is written before it is read
  always_ff @(posedge clk) begin
    if (step) begin
      hb_r <= hb_nxt;
    end
  end

endmodule

@@ src/fss_outq.sv @@
// Result queue: takes a whole burst of result items in a single push and hands
// them out one per cycle from a register while out_stall is low. Depends on fss_pkg.
module fss_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fss_pkg::burst_t burst,
  output logic            room,
  output logic            out_valid,
  input  logic            out_stall,
  output fss_pkg::res_t   head
);

  fss_pkg::res_t [fss_pkg::Q_DEPTH-1:0] q_r, q_nxt;
  logic [fss_pkg::Q_CW-1:0] cnt_r, cnt_nxt, cnt_pop;
  logic                     pop;

  assign out_valid = cnt_r != '0;
  assign head      = q_r[0];
  assign pop       = out_valid && !out_stall;
  // room for a full burst
  assign room      = cnt_r <= fss_pkg::Q_CW'(fss_pkg::Q_DEPTH - fss_pkg::MAX_RES);
  assign cnt_pop   = cnt_r - fss_pkg::Q_CW'(pop);

  always_comb begin
    for (int i = 0; i < fss_pkg::Q_DEPTH; i++) begin
      if (pop && i + 1 < fss_pkg::Q_DEPTH) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      for (int j = 0; j < fss_pkg::MAX_RES; j++) begin
        if (push && fss_pkg::RES_CW'(j) < burst.count &&
            cnt_pop + fss_pkg::Q_CW'(j) == fss_pkg::Q_CW'(i)) begin
          q_nxt[i] = burst.items[j];
        end
      end
    end
    cnt_nxt = cnt_pop + (push ? fss_pkg::Q_CW'(burst.count) : fss_pkg::Q_CW'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

@@ src/filename_segment_sanitizer_top.sv @@
// Top level of the file name segment sanitizer: input register, capacity
// register, decision core and result queue. Depends on fss_pkg, fss_core, fss_outq.
//
// One byte of a name per input item; up to one item is taken every clock
// cycle. An item is registered, then decided by the core, and its results
// enter an eight-entry result queue whose head is a register. The core moves
// an item on only while the queue holds two results or fewer, which leaves
// room for a full burst of six. The one burst per name (at the end of the
// five-byte hold-back, or at the end of a short name) therefore holds the
// input while the queue drains, longer when the receiver stalls; ordinary
// streaming bytes go through at one per cycle while the receiver does not
// stall. cfg_we writes the name capacity (reset 64) and takes effect from
// the next item on.
module filename_segment_sanitizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_byte,
  input  logic        in_has_char,
  input  logic        in_end_of_name,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_name_byte,
  output logic        out_final_byte,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic            in_v_r, in_v_nxt;
  logic [7:0]      byte_r;
  logic            has_r;
  logic            eon_r;
  logic [15:0]     cap_r;
  logic            room;
  logic            step;
  logic            accept;
  fss_pkg::burst_t burst;
  fss_pkg::res_t   head;

  assign step     = in_v_r && room;
  assign in_stall = in_v_r && !room;
  assign accept   = in_valid && !in_stall;
  assign in_v_nxt = accept ? 1'b1 : (step ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      cap_r  <= fss_pkg::CAP_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_char_byte;
      has_r  <= in_has_char;
      eon_r  <= in_end_of_name;
    end
  end

  fss_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .char_byte     (byte_r),
    .has_char      (has_r),
    .end_of_name   (eon_r),
    .name_capacity (cap_r),
    .burst         (burst)
  );

  fss_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .burst     (burst),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_name_byte  = head.name_byte;
  assign out_final_byte = head.final_byte;
  assign out_status     = head.status;

endmodule

@@ tb/filename_segment_sanitizer_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for filename_segment_sanitizer_top: directed and random names,
// a model of the sanitizer and a checker on the result channel.
// Depends on fss_pkg and the sanitizer RTL.
module filename_segment_sanitizer_top_test;
  import fss_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  typedef enum {HOLDING, PLAIN, RESERVED} name_phase_e;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_char_byte = 8'h00;
  logic        in_has_char = 1'b0;
  logic        in_end_of_name = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_name_byte;
  logic        out_final_byte;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  // model state of the name in progress
  logic [7:0]  held [HOLDBACK_DEPTH];
  logic [7:0]  staged [MAX_RES];
  int          kept_n;
  int          emitted_n;
  bit          clean_n;
  name_phase_e phase_n;
  int          capacity = 64;

  res_t        expected_bytes [$];
  bit          idle_on;
  int          stall_left;
  int          mismatches;
  int          items_sent;
  int          names_sent;
  int          results_seen;
  int          cap_settings;
  int          cycle_count;

  string reserved_words [6] = '{"con", "prn", "aux", "nul", "com", "lpt"};
  string kept_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.-_";

  filename_segment_sanitizer_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_byte(in_char_byte),
    .in_has_char(in_has_char),
    .in_end_of_name(in_end_of_name),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_name_byte(out_name_byte),
    .out_final_byte(out_final_byte),
    .out_status(out_status),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  function automatic bit is_kept(logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) ||
           (c >= CH_0 && c <= CH_9) || c == CH_DOT || c == CH_DASH || c == CH_US;
  endfunction

  function automatic void restart_name();
    kept_n = 0;
    emitted_n = 0;
    clean_n = 1'b1;
    phase_n = HOLDING;
  endfunction

  // device-name check on the held bytes; an unterminated base never matches
  function automatic bit reserved_base(int len, bit complete);
    int          b;
    logic [23:0] w;
    b = len;
    for (int i = 0; i < len && i < HOLDBACK_DEPTH; i++) begin
      if (held[i] == CH_DOT) begin
        b = i;
        break;
      end
    end
    if (b == len && !complete) return 1'b0;
    w = {to_lower(held[0]), to_lower(held[1]), to_lower(held[2])};
    if (b == 3) return w == W_CON || w == W_PRN || w == W_AUX || w == W_NUL;
    if (b == 4 && held[3] >= CH_1 && held[3] <= CH_9) return w == W_COM || w == W_LPT;
    return 1'b0;
  endfunction

  // held bytes into staged[], behind an underscore if prefixed, cut to limit
  function automatic int compose(bit prefixed, int limit);
    int len;
    int take;
    int n;
    len = kept_n > HOLDBACK_DEPTH ? HOLDBACK_DEPTH : kept_n;
    n = 0;
    if (prefixed) begin
      staged[0] = CH_US;
      n = 1;
      take = len < limit - 1 ? len : limit - 1;
    end else begin
      take = len < limit ? len : limit;
    end
    for (int i = 0; i < take; i++) begin
      staged[n] = held[i];
      n++;
    end
    return n;
  endfunction

  function automatic void push_result(logic [7:0] b, bit fin, logic [1:0] st);
    res_t r;
    r.name_byte = b;
    r.final_byte = fin;
    r.status = fin ? st : ST_CLEAN;
    expected_bytes.push_back(r);
  endfunction

  function automatic void sanitize_step(logic [7:0] raw, bit has, bit eon);
    int         limit;
    int         n;
    logic [7:0] c;
    bit         r;
    logic [1:0] st;
    limit = (capacity < 2 ? 2 : capacity) - 1;
    if (has) begin
      c = raw;
      if (!is_kept(raw)) begin
        c = CH_US;
        clean_n = 1'b0;
      end
      if (kept_n >= limit) begin
        clean_n = 1'b0;
      end else if (phase_n == HOLDING) begin
        if (kept_n < HOLDBACK_DEPTH) held[kept_n] = c;
        kept_n++;
        if (kept_n >= HOLDBACK_DEPTH) begin
          // decision point: flush all but the last built byte, which stays pending
          r = reserved_base(HOLDBACK_DEPTH, 1'b0);
          n = compose(r, limit);
          for (int i = 0; i < n - 1; i++) push_result(staged[i], 1'b0, ST_CLEAN);
          held[0] = staged[n - 1];
          emitted_n = n;
          phase_n = r ? RESERVED : PLAIN;
        end
      end else begin
        kept_n++;
        if (emitted_n < limit) begin
          push_result(held[0], 1'b0, ST_CLEAN);
          held[0] = c;
          emitted_n++;
        end
      end
    end
    if (eon) begin
      if (phase_n == HOLDING) begin
        if (kept_n == 0 || (kept_n == 1 && held[0] == CH_DOT) ||
            (kept_n == 2 && held[0] == CH_DOT && held[1] == CH_DOT)) begin
          n = limit < 4 ? limit : 4;
          for (int i = 0; i < n; i++) staged[i] = FB_WORD[31 - 8 * i -: 8];
          st = ST_FALLBACK;
        end else if (reserved_base(kept_n, 1'b1)) begin
          n = compose(1'b1, limit);
          st = ST_RESERVED;
        end else begin
          n = compose(1'b0, limit);
          st = clean_n ? ST_CLEAN : ST_DIRTY;
        end
        for (int i = 0; i < n; i++) push_result(staged[i], i == n - 1, st);
      end else begin
        push_result(held[0], 1'b1,
                    phase_n == RESERVED ? ST_RESERVED : (clean_n ? ST_CLEAN : ST_DIRTY));
      end
      restart_name();
    end
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte %02h", out_name_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_name_byte !== want.name_byte)
          report_mismatch($sformatf("name_byte %02h, want %02h", out_name_byte, want.name_byte));
        if (out_final_byte !== want.final_byte)
          report_mismatch($sformatf("final_byte %b, want %b", out_final_byte, want.final_byte));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
      end
    end
  end

  // receiver stalls in short random bursts
  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 4);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_bytes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_item(input logic [7:0] b, input bit has, input bit eon);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_byte <= b;
    in_has_char <= has;
    in_end_of_name <= eon;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sanitize_step(b, has, eon);
    if (has || eon) items_sent++;
    if (eon) names_sent++;
  endtask

  // one name; empty queue sends a bare terminator
  task automatic send_bytes(input logic [7:0] q[$], input bit split_end, input bit noisy);
    if (q.size() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    foreach (q[i]) begin
      if (noisy && $urandom_range(0, 9) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(q[i], 1'b1, !split_end && i == q.size() - 1);
    end
    if (split_end) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q [$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_bytes(q, 1'b0, 1'b0);
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] v);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = v;
    cap_settings++;
  endtask

  function automatic logic [7:0] pick_kept();
    return kept_chars[$urandom_range(0, kept_chars.len() - 1)];
  endfunction

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    return ($urandom_range(0, 1) && c >= CH_LA && c <= CH_LZ) ? c - 8'd32 : c;
  endfunction

  task automatic test_fallback_names();
    send_text("");
    send_text(".");
    send_text("..");
  endtask

  task automatic test_reserved_names();
    send_text("CoN");
    send_text("Lpt9.x");
  endtask

  // NUL and high bytes become underscores; an empty item in between is ignored
  task automatic test_byte_replacement();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item("Z", 1'b1, 1'b1);
  endtask

  task automatic test_small_capacity();
    write_capacity(16'd0);
    send_text("nul");
    send_text("");
    write_capacity(16'd1);
    send_text("ab");
  endtask

  // limit shrinks below the kept count while a name is streaming
  task automatic test_capacity_change();
    write_capacity(16'd6);
    send_item("a", 1'b1, 1'b0);
    send_item("b", 1'b1, 1'b0);
    send_item("c", 1'b1, 1'b0);
    send_item("d", 1'b1, 1'b0);
    send_item("e", 1'b1, 1'b0);
    write_capacity(16'd3);
    send_item("f", 1'b1, 1'b1);
  endtask

  task automatic test_random_names();
    logic [15:0] caps [8];
    logic [7:0]  q [$];
    int          goal;
    string       word;
    caps = '{16'hFFFF, 16'd2, 16'd1, 16'd7, 16'd0, 16'd3, 16'd6, 16'd64};
    caps[5] = 16'($urandom_range(3, 12));
    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      goal = items_sent + 40;
      while (items_sent < goal) begin
        idle_on = (p != 7) && ($urandom_range(0, 9) < 7);
        q.delete();
        case ($urandom_range(0, 9))
          0: repeat ($urandom_range(0, 3)) q.push_back(CH_DOT);
          1, 2, 3: begin
            word = reserved_words[$urandom_range(0, 5)];
            for (int i = 0; i < 3; i++) q.push_back(mixed_case(word[i]));
            if (word == "com" || word == "lpt")
              q.push_back(($urandom_range(0, 5) == 0) ? CH_0 : 8'($urandom_range(CH_1, CH_9)));
            case ($urandom_range(0, 2))
              1: begin
                q.push_back(CH_DOT);
                repeat ($urandom_range(0, 4)) q.push_back(pick_kept());
              end
              2: q.push_back(pick_kept());
              default: ;
            endcase
          end
          4, 5, 6: repeat ($urandom_range(1, 12)) q.push_back(pick_kept());
          7: repeat ($urandom_range(1, 10)) q.push_back(8'($urandom_range(0, 255)));
          8: repeat ($urandom_range(10, 80))
               q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : pick_kept());
          default: repeat ($urandom_range(2, 9))
                     q.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255))
                                                             : pick_kept());
        endcase
        send_bytes(q, $urandom_range(0, 3) == 0, p != 7);
        if ($urandom_range(0, 29) == 0) wait_quiet();
      end
    end
  endtask

  initial begin
    for (int i = 0; i < HOLDBACK_DEPTH; i++) held[i] = 8'h00;
    restart_name();
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fallback_names();
    test_reserved_names();
    test_byte_replacement();
    test_small_capacity();
    test_capacity_change();
    test_random_names();
    idle_on = 1'b0;
    wait_quiet();
    $display("%0d names in %0d items, %0d result bytes checked", names_sent, items_sent,
             results_seen);
    $display("capacities 0..65535 over %0d writes, random stalls on both channels",
             cap_settings);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
